[design/psob_pkg.sv]
// Package for the premultiplied source-over blender: payload structs, command and
// register codes, the sRGB-to-linear table and the shared arithmetic helpers.
// No dependencies.
`timescale 1ns / 1ps

package psob_pkg;

   // Pipeline depth: accept edge to result cycle
   localparam int DEPTH = 10;

   typedef enum logic [1:0] {
      CMD_STRAIGHT = 2'd0,
      CMD_SRGB     = 2'd1,
      CMD_COVERAGE = 2'd2,
      CMD_SOLID    = 2'd3
   } blend_cmd_type;

   typedef enum logic [1:0] {
      REG_FILL_RED   = 2'd0,
      REG_FILL_GREEN = 2'd1,
      REG_FILL_BLUE  = 2'd2,
      REG_FILL_ALPHA = 2'd3
   } reg_index_type;

   localparam logic [7:0] FILL_COLOR_RESET = 8'd0;
   localparam logic [7:0] FILL_ALPHA_RESET = 8'd255;
   localparam logic [7:0] FULL_SCALE       = 8'd255;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] src_red;
      logic [7:0] src_green;
      logic [7:0] src_blue;
      logic [7:0] src_alpha;
      logic [7:0] coverage;
      logic [7:0] dst_red;
      logic [7:0] dst_green;
      logic [7:0] dst_blue;
      logic [7:0] dst_alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_type;

   // round(255 * lin(i / 255)) for the sRGB transfer curve
   localparam logic [7:0] SRGB_LUT [0:255] = '{
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,
      8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
      8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
      8'd2,   8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
      8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,
      8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
      8'd8,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd10,
      8'd10,  8'd10,  8'd11,  8'd11,  8'd12,  8'd12,  8'd12,  8'd13,
      8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
      8'd17,  8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,
      8'd20,  8'd21,  8'd22,  8'd22,  8'd23,  8'd23,  8'd24,  8'd24,
      8'd25,  8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,
      8'd30,  8'd30,  8'd31,  8'd32,  8'd32,  8'd33,  8'd34,  8'd35,
      8'd35,  8'd36,  8'd37,  8'd37,  8'd38,  8'd39,  8'd40,  8'd41,
      8'd41,  8'd42,  8'd43,  8'd44,  8'd45,  8'd45,  8'd46,  8'd47,
      8'd48,  8'd49,  8'd50,  8'd51,  8'd51,  8'd52,  8'd53,  8'd54,
      8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
      8'd63,  8'd64,  8'd65,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,
      8'd71,  8'd72,  8'd73,  8'd74,  8'd76,  8'd77,  8'd78,  8'd79,
      8'd80,  8'd81,  8'd82,  8'd84,  8'd85,  8'd86,  8'd87,  8'd88,
      8'd90,  8'd91,  8'd92,  8'd93,  8'd95,  8'd96,  8'd97,  8'd99,
      8'd100, 8'd101, 8'd103, 8'd104, 8'd105, 8'd107, 8'd108, 8'd109,
      8'd111, 8'd112, 8'd114, 8'd115, 8'd116, 8'd118, 8'd119, 8'd121,
      8'd122, 8'd124, 8'd125, 8'd127, 8'd128, 8'd130, 8'd131, 8'd133,
      8'd134, 8'd136, 8'd138, 8'd139, 8'd141, 8'd142, 8'd144, 8'd146,
      8'd147, 8'd149, 8'd151, 8'd152, 8'd154, 8'd156, 8'd157, 8'd159,
      8'd161, 8'd163, 8'd164, 8'd166, 8'd168, 8'd170, 8'd171, 8'd173,
      8'd175, 8'd177, 8'd179, 8'd181, 8'd183, 8'd184, 8'd186, 8'd188,
      8'd190, 8'd192, 8'd194, 8'd196, 8'd198, 8'd200, 8'd202, 8'd204,
      8'd206, 8'd208, 8'd210, 8'd212, 8'd214, 8'd216, 8'd218, 8'd220,
      8'd222, 8'd224, 8'd226, 8'd229, 8'd231, 8'd233, 8'd235, 8'd237,
      8'd239, 8'd242, 8'd244, 8'd246, 8'd248, 8'd250, 8'd253, 8'd255
   };

   // (prod + 127) / 255 for a product of two bytes, with no divider:
   // floor(x / 255) == (x + 1 + (x >> 8)) >> 8 for x below 65536
   function automatic logic [7:0] mul8_round(input logic [15:0] prod);
      logic [16:0] x;
      logic [16:0] y;
      x = {1'b0, prod} + 17'd127;
      y = x + 17'd1 + {8'b0, x[16:8]};
      return y[15:8];
   endfunction

   // One restoring division step: returns {quotient bit, new remainder}
   function automatic logic [8:0] div_step(input logic [7:0] rem, input logic next_bit,
                                           input logic [7:0] divisor);
      logic [8:0] t;
      logic [8:0] d;
      t = {rem, next_bit};
      d = {1'b0, divisor};
      if (t >= d) begin
         return {1'b1, 8'(t - d)};
      end else begin
         return {1'b0, t[7:0]};
      end
   endfunction

endpackage

[design/premultiplied_source_over_blender.sv]
// Premultiplied source-over blender, top level: ten-stage pixel pipeline and fill registers.
// Depends on psob_pkg.
// A beat accepted at a clock edge passes down every stage and shows on rsp_* for one cycle.
// Throughput: one beat per cycle; busy stays low, and the receiver cannot stall.
// Depth is set by the sRGB unpremultiply divider (two quotient bits per stage, four
// stages) followed by the table lookup and the remultiply and blend multiply stages.
// Reset (synchronous, active high) empties the pipeline and loads the fill registers.
`timescale 1ns / 1ps

module premultiplied_source_over_blender (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  psob_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output psob_pkg::rsp_type rsp_payload,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_write_data
);
   import psob_pkg::*;

   // Everything one beat carries down the pipe. Each stage fills in its own fields;
   // fields that no later stage reads fall away in synthesis.
   typedef struct packed {
      blend_cmd_type    cmd;
      logic [7:0]       src_alpha;
      logic [3:0][7:0]  dst;          // premultiplied destination, alpha on top
      logic [2:0][15:0] straight_prod; // colour * src_alpha, straight command
      logic [2:0][7:0]  s_straight;
      logic [15:0]      cov_prod;     // fill_alpha * coverage
      logic [7:0]       fill_a;       // effective fill alpha
      logic [2:0][15:0] fill_prod;
      logic [2:0][7:0]  s_fill;
      logic [2:0][7:0]  rem;          // divider remainder per lane
      logic [2:0][7:0]  num_lo;       // numerator bits not yet shifted in
      logic [2:0][7:0]  quo;          // quotient bits so far
      logic [2:0]       clamp;        // colour at or above alpha: saturate
      logic [2:0][7:0]  lin;
      logic [2:0][15:0] lin_prod;
      logic [3:0][7:0]  src;          // premultiplied source, alpha on top
      logic [3:0][15:0] dst_prod;
      logic [3:0][7:0]  result;
   } pipe_type;

   localparam int DIV_FIRST = 2;
   localparam int DIV_LAST  = 5;

   logic [2:0][7:0] fill_color_ff;
   logic [7:0]      fill_alpha_ff;
   logic            accept;
   logic [DEPTH:1]  valid_ff;
   logic [DEPTH:1]  valid_in;
   pipe_type        st_ff [1:DEPTH];
   pipe_type        st_in [1:DEPTH];

   // No backpressure anywhere: every start is taken.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Fill registers. The user must let writes arrive only while the pipe is empty,
   // so later stages may read them directly; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_color_ff <= {3{FILL_COLOR_RESET}};
         fill_alpha_ff <= FILL_ALPHA_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_FILL_RED:   fill_color_ff[0] <= csr_write_data;
            REG_FILL_GREEN: fill_color_ff[1] <= csr_write_data;
            REG_FILL_BLUE:  fill_color_ff[2] <= csr_write_data;
            REG_FILL_ALPHA: fill_alpha_ff    <= csr_write_data;
            default:        fill_alpha_ff    <= fill_alpha_ff;
         endcase
      end
   end

   assign valid_in = {valid_ff[DEPTH-1:1], accept};

   always_comb begin
      logic [2:0][7:0]  src_color;
      logic [15:0]      num;
      logic [8:0]       step_res;

      src_color = {req_payload.src_blue, req_payload.src_green, req_payload.src_red};

      // Stage 1: capture the beat, form the products and the divider numerator
      // c * 255 + a / 2; its top byte is below alpha whenever colour is below alpha.
      st_in[1]           = st_ff[1];
      st_in[1].cmd       = blend_cmd_type'(req_payload.command);
      st_in[1].src_alpha = req_payload.src_alpha;
      st_in[1].dst       = {req_payload.dst_alpha, req_payload.dst_blue,
                            req_payload.dst_green, req_payload.dst_red};
      st_in[1].cov_prod  = 16'(fill_alpha_ff) * 16'(req_payload.coverage);
      for (int i = 0; i < 3; i++) begin
         st_in[1].straight_prod[i] = 16'(src_color[i]) * 16'(req_payload.src_alpha);
         num = {src_color[i], 8'b0} - 16'(src_color[i]) + 16'(req_payload.src_alpha[7:1]);
         st_in[1].rem[i]    = num[15:8];
         st_in[1].num_lo[i] = num[7:0];
         st_in[1].quo[i]    = '0;
         st_in[1].clamp[i]  = src_color[i] >= req_payload.src_alpha;
      end

      for (int s = 2; s <= DEPTH; s++) begin
         st_in[s] = st_ff[s-1];
      end

      // Stages 2 to 5: two quotient bits per stage in each colour lane
      for (int s = DIV_FIRST; s <= DIV_LAST; s++) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 2; k++) begin
               step_res = div_step(st_in[s].rem[i], st_in[s].num_lo[i][7],
                                   st_in[s].src_alpha);
               st_in[s].rem[i]    = step_res[7:0];
               st_in[s].quo[i]    = {st_in[s].quo[i][6:0], step_res[8]};
               st_in[s].num_lo[i] = {st_in[s].num_lo[i][6:0], 1'b0};
            end
         end
      end

      // Stage 2: round the straight products; scale fill alpha by coverage for CMD_COVERAGE
      for (int i = 0; i < 3; i++) begin
         st_in[2].s_straight[i] = mul8_round(st_ff[1].straight_prod[i]);
      end
      st_in[2].fill_a = (st_ff[1].cmd == CMD_COVERAGE) ? mul8_round(st_ff[1].cov_prod)
                                                       : fill_alpha_ff;

      // Stage 3: fill colour times effective alpha
      for (int i = 0; i < 3; i++) begin
         st_in[3].fill_prod[i] = 16'(fill_color_ff[i]) * 16'(st_ff[2].fill_a);
      end

      // Stage 4: round the fill products
      for (int i = 0; i < 3; i++) begin
         st_in[4].s_fill[i] = mul8_round(st_ff[3].fill_prod[i]);
      end

      // Stage 6: saturate the unpremultiplied colour and linearize it
      for (int i = 0; i < 3; i++) begin
         st_in[6].lin[i] = SRGB_LUT[st_ff[5].clamp[i] ? FULL_SCALE : st_ff[5].quo[i]];
      end

      // Stage 7: premultiply the linear colour again
      for (int i = 0; i < 3; i++) begin
         st_in[7].lin_prod[i] = 16'(st_ff[6].lin[i]) * 16'(st_ff[6].src_alpha);
      end

      // Stage 8: pick the premultiplied source for this command
      unique case (st_ff[7].cmd)
         CMD_STRAIGHT: begin
            st_in[8].src = {st_ff[7].src_alpha, st_ff[7].s_straight};
         end
         CMD_SRGB: begin
            st_in[8].src[3] = st_ff[7].src_alpha;
            for (int i = 0; i < 3; i++) begin
               st_in[8].src[i] = mul8_round(st_ff[7].lin_prod[i]);
            end
         end
         CMD_COVERAGE, CMD_SOLID: begin
            st_in[8].src = {st_ff[7].fill_a, st_ff[7].s_fill};
         end
         default: begin
            st_in[8].src = '0;
         end
      endcase

      // Stage 9: destination times inverse source alpha
      for (int k = 0; k < 4; k++) begin
         st_in[9].dst_prod[k] = 16'(st_ff[8].dst[k]) * 16'(FULL_SCALE - st_ff[8].src[3]);
      end

      // Stage 10: add the source; the sum wraps at eight bits
      for (int k = 0; k < 4; k++) begin
         st_in[10].result[k] = st_ff[9].src[k] + mul8_round(st_ff[9].dst_prod[k]);
      end
   end

   // Valid bits: the only control state of the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload: advance every cycle, no reset needed
   always_ff @(posedge clock) begin
      for (int s = 1; s <= DEPTH; s++) begin
         st_ff[s] <= st_in[s];
      end
   end

   assign rsp_strobe            = valid_ff[DEPTH];
   assign rsp_payload.out_red   = st_ff[DEPTH].result[0];
   assign rsp_payload.out_green = st_ff[DEPTH].result[1];
   assign rsp_payload.out_blue  = st_ff[DEPTH].result[2];
   assign rsp_payload.out_alpha = st_ff[DEPTH].result[3];

endmodule

[design/psob_checker.sv]
// Port-level checker for the premultiplied source-over blender, with its bind.
// Depends on psob_pkg and premultiplied_source_over_blender.
`timescale 1ns / 1ps

module psob_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input psob_pkg::req_type req_payload,
   input logic              rsp_strobe,
   input psob_pkg::rsp_type rsp_payload
);
   import psob_pkg::*;

   logic accept;
   assign accept = start && !busy;

   // Every accepted beat yields a result after the pipeline depth
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##DEPTH rsp_strobe)
      else $error("accepted beat produced no result");

   // No result appears without a beat accepted the pipeline depth earlier
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, DEPTH))
      else $error("result without matching accepted beat");

   // Opaque straight source replaces the destination
   a_opaque_source: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.command == CMD_STRAIGHT && req_payload.src_alpha == 8'd255
      |-> ##DEPTH rsp_payload.out_red == $past(req_payload.src_red, DEPTH)
          && rsp_payload.out_green == $past(req_payload.src_green, DEPTH)
          && rsp_payload.out_blue == $past(req_payload.src_blue, DEPTH)
          && rsp_payload.out_alpha == 8'd255)
      else $error("opaque source did not replace destination");

   // Transparent straight source leaves the destination unchanged
   a_clear_source: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.command == CMD_STRAIGHT && req_payload.src_alpha == 8'd0
      |-> ##DEPTH rsp_payload.out_red == $past(req_payload.dst_red, DEPTH)
          && rsp_payload.out_green == $past(req_payload.dst_green, DEPTH)
          && rsp_payload.out_blue == $past(req_payload.dst_blue, DEPTH)
          && rsp_payload.out_alpha == $past(req_payload.dst_alpha, DEPTH))
      else $error("transparent source altered destination");

endmodule

bind premultiplied_source_over_blender psob_checker u_psob_checker (.*);

[sim/premultiplied_source_over_blender_tb.sv]
// Self-checking testbench for premultiplied_source_over_blender: directed pixels per
// command, then a long random stream over several fill settings; depends on psob_pkg.
// Results are predicted in the bench and compared field by field in arrival order.
`timescale 1ns / 1ps

module premultiplied_source_over_blender_tb;

   import psob_pkg::*;

   // Watchdog: about 2000 beats plus the phase drains fit well inside this limit.
   localparam int CYCLE_LIMIT = 100000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_BEATS = 325;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;
   logic    csr_write_enable;
   logic [1:0] csr_index;
   logic [7:0] csr_write_data;

   // Bench copy of the fill registers and the sRGB decode curve
   logic [7:0]  fill_regs [4];
   int unsigned linear_of_srgb [256];

   rsp_type     expected_pixels [$];
   int          mismatches = 0;
   int          cycle_count = 0;
   bit          steady_stream = 1'b0;

   premultiplied_source_over_blender dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_payload      (req_payload),
      .rsp_strobe       (rsp_strobe),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Blend predictor
   // ---------------------------------------------------------------------------

   // Byte product rounded to nearest over 255
   function automatic int unsigned scale_round(input int unsigned x, input int unsigned y);
      return (x * y + 127) / 255;
   endfunction

   // Undo premultiply (clamped), decode sRGB, premultiply again
   function automatic int unsigned decode_srgb(input int unsigned c, input int unsigned a);
      int unsigned straight;
      if (a == 0) begin
         straight = 0;
      end else begin
         straight = (c * 255 + a / 2) / a;
         if (straight > 255) begin
            straight = 255;
         end
      end
      return scale_round(linear_of_srgb[straight], a);
   endfunction

   function automatic rsp_type blend_pixel(input req_type p);
      int unsigned src [4];
      int unsigned dst [4];
      int unsigned a;
      int unsigned inv;
      logic [7:0]  sum [4];
      rsp_type     r;
      dst = '{p.dst_red, p.dst_green, p.dst_blue, p.dst_alpha};
      case (blend_cmd_type'(p.command))
         CMD_STRAIGHT: begin
            src[0] = scale_round(p.src_red, p.src_alpha);
            src[1] = scale_round(p.src_green, p.src_alpha);
            src[2] = scale_round(p.src_blue, p.src_alpha);
            src[3] = p.src_alpha;
         end
         CMD_SRGB: begin
            src[0] = decode_srgb(p.src_red, p.src_alpha);
            src[1] = decode_srgb(p.src_green, p.src_alpha);
            src[2] = decode_srgb(p.src_blue, p.src_alpha);
            src[3] = p.src_alpha;
         end
         default: begin
            // Coverage mask scales the fill alpha; solid fill takes it as is
            a = fill_regs[REG_FILL_ALPHA];
            if (blend_cmd_type'(p.command) == CMD_COVERAGE) begin
               a = (a * p.coverage + 127) / 255;
            end
            src[0] = scale_round(fill_regs[REG_FILL_RED], a);
            src[1] = scale_round(fill_regs[REG_FILL_GREEN], a);
            src[2] = scale_round(fill_regs[REG_FILL_BLUE], a);
            src[3] = a;
         end
      endcase
      // Source over: dst scaled by the inverse source alpha, sum wraps at 8 bits
      inv = 255 - src[3];
      for (int k = 0; k < 4; k++) begin
         sum[k] = 8'(src[k] + scale_round(dst[k], inv));
      end
      r.out_red   = sum[0];
      r.out_green = sum[1];
      r.out_blue  = sum[2];
      r.out_alpha = sum[3];
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic req_type make_pixel(input blend_cmd_type cmd,
                                          input logic [7:0] sr, sg, sb, sa, cov,
                                          input logic [7:0] dr, dg, db, da);
      req_type p;
      p.command   = cmd;
      p.src_red   = sr;
      p.src_green = sg;
      p.src_blue  = sb;
      p.src_alpha = sa;
      p.coverage  = cov;
      p.dst_red   = dr;
      p.dst_green = dg;
      p.dst_blue  = db;
      p.dst_alpha = da;
      return p;
   endfunction

   // Random byte leaning on the extremes
   function automatic logic [7:0] pick_byte();
      int unsigned roll;
      roll = $urandom_range(7);
      if (roll == 0) begin
         return 8'd0;
      end else if (roll == 1) begin
         return 8'd255;
      end
      return 8'($urandom_range(255));
   endfunction

   // Present one beat and hold it until accepted; record its expected result.
   // start stays high on return so back-to-back beats need no extra edge.
   task automatic send_pixel(input req_type pixel);
      if (!steady_stream && $urandom_range(99) < 7) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= pixel;
      do @(posedge clock); while (busy !== 1'b0);
      expected_pixels.push_back(blend_pixel(pixel));
   endtask

   // Drop start and wait for every pending result to arrive
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (expected_pixels.size() != 0);
   endtask

   // Write all four fill registers on consecutive edges; call only when idle
   task automatic load_fill(input logic [7:0] r, g, b, a);
      logic [7:0] vals [4];
      vals = '{r, g, b, a};
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= i[1:0];
         csr_write_data   <= vals[i];
         @(posedge clock);
         fill_regs[i] = vals[i];
      end
      csr_write_enable <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Result checker: every strobe beat is matched against the oldest prediction
   // ---------------------------------------------------------------------------

   task automatic compare_channel(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
                     name, cycle_count, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result beat with nothing pending at cycle %0d", cycle_count);
            end
         end else begin
            want = expected_pixels.pop_front();
            compare_channel("out_red", want.out_red, rsp_payload.out_red);
            compare_channel("out_green", want.out_green, rsp_payload.out_green);
            compare_channel("out_blue", want.out_blue, rsp_payload.out_blue);
            compare_channel("out_alpha", want.out_alpha, rsp_payload.out_alpha);
         end
      end
   end

   // Watchdog: a hung pipeline or a lost beat ends the run here
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("premultiplied_source_over_blender verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Straight RGBA: opaque, transparent, half alpha, black over white
   task automatic test_straight_source();
      send_pixel(make_pixel(CMD_STRAIGHT, 255, 255, 255, 255, 0, 0, 0, 0, 0));
      send_pixel(make_pixel(CMD_STRAIGHT, 255, 255, 255, 0, 255, 255, 255, 255, 255));
      send_pixel(make_pixel(CMD_STRAIGHT, 200, 100, 50, 128, 0, 90, 60, 30, 128));
      send_pixel(make_pixel(CMD_STRAIGHT, 0, 0, 0, 255, 0, 255, 255, 255, 255));
      // Destination colour above its alpha: check the sum for wrap
      send_pixel(make_pixel(CMD_STRAIGHT, 255, 1, 254, 1, 0, 255, 255, 255, 0));
      drain();
   endtask

   // Premultiplied sRGB: zero alpha, colour above alpha (clamp), full alpha,
   // tiny alpha, and a typical translucent pixel
   task automatic test_srgb_source();
      send_pixel(make_pixel(CMD_SRGB, 200, 10, 255, 0, 0, 40, 80, 120, 160));
      send_pixel(make_pixel(CMD_SRGB, 200, 255, 10, 100, 0, 10, 20, 30, 40));
      send_pixel(make_pixel(CMD_SRGB, 0, 128, 255, 255, 0, 255, 255, 255, 255));
      send_pixel(make_pixel(CMD_SRGB, 1, 0, 1, 1, 0, 0, 0, 0, 0));
      send_pixel(make_pixel(CMD_SRGB, 60, 120, 30, 150, 0, 200, 100, 50, 255));
      send_pixel(make_pixel(CMD_SRGB, 255, 255, 255, 255, 0, 255, 255, 255, 255));
      drain();
   endtask

   // Coverage mask: first on the reset fill (opaque black), then on a set colour,
   // with zero coverage leaving the destination untouched
   task automatic test_coverage_mask();
      send_pixel(make_pixel(CMD_COVERAGE, 255, 255, 255, 255, 255, 200, 150, 100, 255));
      send_pixel(make_pixel(CMD_COVERAGE, 17, 34, 51, 68, 128, 200, 150, 100, 255));
      drain();
      load_fill(200, 100, 50, 180);
      send_pixel(make_pixel(CMD_COVERAGE, 255, 0, 255, 0, 0, 77, 88, 99, 111));
      send_pixel(make_pixel(CMD_COVERAGE, 0, 255, 0, 255, 255, 0, 0, 0, 0));
      send_pixel(make_pixel(CMD_COVERAGE, 0, 0, 0, 0, 1, 255, 255, 255, 255));
      send_pixel(make_pixel(CMD_COVERAGE, 0, 0, 0, 0, 127, 30, 60, 90, 120));
      drain();
   endtask

   // Solid fill at the extremes of the fill registers, then a mixed half-alpha setting
   task automatic test_solid_fill();
      load_fill(255, 255, 255, 255);
      send_pixel(make_pixel(CMD_SOLID, 0, 0, 0, 0, 0, 10, 20, 30, 40));
      drain();
      load_fill(0, 0, 0, 0);
      send_pixel(make_pixel(CMD_SOLID, 255, 255, 255, 255, 255, 210, 220, 230, 240));
      drain();
      load_fill(255, 128, 0, 128);
      send_pixel(make_pixel(CMD_SOLID, 1, 2, 3, 4, 5, 255, 255, 255, 255));
      send_pixel(make_pixel(CMD_SOLID, 9, 8, 7, 6, 5, 0, 0, 0, 0));
      drain();
   endtask

   // Random stream over several fill settings; one phase runs without gaps.
   // Most sRGB beats are well-formed premultiplied pixels, the rest are noise.
   task automatic test_random_blends();
      req_type       p;
      blend_cmd_type cmd;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       load_fill(0, 0, 0, 0);
            1:       load_fill(255, 255, 255, 255);
            default: load_fill(pick_byte(), pick_byte(), pick_byte(), pick_byte());
         endcase
         steady_stream = (phase == 3);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            cmd = blend_cmd_type'($urandom_range(3));
            p = make_pixel(cmd, pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                           pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte());
            if (cmd == CMD_SRGB && $urandom_range(99) < 75) begin
               p.src_red   = 8'($urandom_range(p.src_alpha));
               p.src_green = 8'($urandom_range(p.src_alpha));
               p.src_blue  = 8'($urandom_range(p.src_alpha));
            end
            send_pixel(p);
         end
         drain();
      end
      steady_stream = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------

   initial begin
      real e;
      real lin;
      // Hold every input at a known value from time zero
      reset            = 1'b1;
      start            = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      fill_regs        = '{FILL_COLOR_RESET, FILL_COLOR_RESET, FILL_COLOR_RESET,
                           FILL_ALPHA_RESET};

      // Build the sRGB decode curve from the transfer function itself
      for (int i = 0; i < 256; i++) begin
         e = i / 255.0;
         if (e <= 0.04045) begin
            lin = e / 12.92;
         end else begin
            lin = $pow((e + 0.055) / 1.055, 2.4);
         end
         linear_of_srgb[i] = $rtoi(255.0 * lin + 0.5);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_straight_source();
      test_srgb_source();
      test_coverage_mask();
      test_solid_fill();
      test_random_blends();

      // Everything has drained; idle past the pipeline depth to catch stray beats
      repeat (DEPTH + 5) @(posedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("premultiplied_source_over_blender verification clean");
      end else begin
         $display("premultiplied_source_over_blender verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
design/psob_pkg.sv
design/premultiplied_source_over_blender.sv
design/psob_checker.sv
sim/premultiplied_source_over_blender_tb.sv
